// ----- rtl/multichannel_sample_framer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sample framer
// Implication checks, enabled unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_FRAMER_TOP_ASSERT_SVH
`define MULTICHANNEL_SAMPLE_FRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define MSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");
// Next-cycle implication.
`define MSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");
`else
`define MSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/msf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sample framer package
// Sizes, configuration types, controller states and command/status groups.
// ----------------------------------------------------------------------------
package msf_pkg;

    localparam int MAX_CHANNELS    = 4;
    localparam int MAX_SAMPLES     = 16;
    localparam int MAX_BUFFERS     = 2;
    localparam int INPUT_CHANNELS  = 4;
    localparam int SAMPLE_W        = 32;
    localparam int FRAME_WORDS_MAX = MAX_CHANNELS * MAX_SAMPLES;
    localparam int STORE_DEPTH     = FRAME_WORDS_MAX * MAX_BUFFERS;

    localparam int CC_W     = 3;
    localparam int SPF_W    = 5;
    localparam int NB_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int POS_W  = $clog2(MAX_SAMPLES);
    localparam int BUF_W  = $clog2(MAX_BUFFERS);
    localparam int FW_W   = $clog2(FRAME_WORDS_MAX + 1);
    localparam int IDX_W  = $clog2(FRAME_WORDS_MAX);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_CHANNELS   = 2'd0,
        CFG_SAMPLES_PER_FRAME = 2'd1,
        CFG_BUFFERS_IN_USE    = 2'd2,
        CFG_LAYOUT_MODE       = 2'd3
    } msf_cfg_idx_t;

    typedef enum logic {
        LAYOUT_CHANNEL_MAJOR = 1'b0,
        LAYOUT_SAMPLE_MAJOR  = 1'b1
    } msf_layout_t;

    // Effective (saturated) configuration.
    typedef struct packed {
        logic [CC_W-1:0]  cc;
        logic [SPF_W-1:0] spf;
        logic [NB_W-1:0]  nb;
        msf_layout_t      layout;
    } msf_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WRITE = 2'd1,
        ST_READ  = 2'd2
    } msf_state_t;

    typedef struct packed {
        logic load;        // capture the input vector
        logic write;       // store one channel of the vector
        logic close;       // end of vector: advance position and buffer
        logic read_issue;  // read one frame word
    } msf_cmd_t;

    typedef struct packed {
        logic wr_last;     // current channel is the last active one
        logic frame_full;  // this vector completes the frame
        logic rd_last;     // current read is the final frame word
        logic can_issue;   // read pipeline has room
    } msf_status_t;

endpackage

// ----- rtl/msf_cfg.sv -----
// ----------------------------------------------------------------------------
// Sample framer configuration registers
// Holds the four registers and saturates them into their working ranges.
// ----------------------------------------------------------------------------
module msf_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output msf_pkg::msf_cfg_t         cfg
);
    import msf_pkg::*;

    logic [CC_W-1:0]  cc_reg;
    logic [SPF_W-1:0] spf_reg;
    logic [NB_W-1:0]  nb_reg;
    logic             layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg     <= CC_W'(MAX_CHANNELS);
            spf_reg    <= SPF_W'(MAX_SAMPLES);
            nb_reg     <= NB_W'(MAX_BUFFERS);
            layout_reg <= LAYOUT_CHANNEL_MAJOR;
        end
        else if (cfg_wen)
        begin
            unique case (msf_cfg_idx_t'(cfg_index))
                CFG_ACTIVE_CHANNELS:   cc_reg     <= cfg_wdata[CC_W-1:0];
                CFG_SAMPLES_PER_FRAME: spf_reg    <= cfg_wdata[SPF_W-1:0];
                CFG_BUFFERS_IN_USE:    nb_reg     <= cfg_wdata[NB_W-1:0];
                CFG_LAYOUT_MODE:       layout_reg <= cfg_wdata[0];
                default:               ;
            endcase
        end
    end

    // Zero acts as one, anything above the maximum acts as the maximum.
    always_comb
    begin
        cfg.cc = (cc_reg == '0) ? CC_W'(1)
               : (cc_reg > CC_W'(MAX_CHANNELS)) ? CC_W'(MAX_CHANNELS) : cc_reg;
        cfg.spf = (spf_reg == '0) ? SPF_W'(1)
                : (spf_reg > SPF_W'(MAX_SAMPLES)) ? SPF_W'(MAX_SAMPLES) : spf_reg;
        cfg.nb = (nb_reg == '0) ? NB_W'(1)
               : (nb_reg > NB_W'(MAX_BUFFERS)) ? NB_W'(MAX_BUFFERS) : nb_reg;
        cfg.layout = msf_layout_t'(layout_reg);
    end

endmodule

// ----- rtl/msf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sample framer controller
// Sequences vector capture, per-channel stores and the frame read-out.
// ----------------------------------------------------------------------------
module msf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  msf_pkg::msf_status_t status,
    output msf_pkg::msf_cmd_t    cmd
);
    import msf_pkg::*;

    msf_state_t state_reg;
    msf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (status.wr_last)
                begin
                    cmd.close  = 1'b1;
                    state_next = status.frame_full ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                // Leave once the final read is issued; the output pipe drains alone.
                if (status.can_issue)
                begin
                    cmd.read_issue = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/msf_datapath.sv -----
// ----------------------------------------------------------------------------
// Sample framer datapath
// Frame store, address generation, position/buffer tracking and output pipe.
// ----------------------------------------------------------------------------
module msf_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msf_pkg::msf_cfg_t                 cfg,
    input  msf_pkg::msf_cmd_t                 cmd,
    output msf_pkg::msf_status_t              status,
    input  logic [msf_pkg::INPUT_CHANNELS*msf_pkg::SAMPLE_W-1:0] in_samples,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [msf_pkg::SAMPLE_W-1:0]      out_word,
    output logic [msf_pkg::BUF_W-1:0]         out_buf,
    output logic                              out_last
);
    import msf_pkg::*;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic [SAMPLE_W-1:0] samp_reg [INPUT_CHANNELS];
    logic [CH_W-1:0]     ch_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [BUF_W-1:0]    buf_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ADDR_W-1:0]   rd_base_reg;
    logic [BUF_W-1:0]    rd_buf_reg;

    // Read stage (memory output) and output stage.
    logic                s1_valid_reg;
    logic                s1_last_reg;
    logic [BUF_W-1:0]    s1_buf_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                out_valid_reg;
    logic                out_last_reg;
    logic [BUF_W-1:0]    out_buf_reg;
    logic [SAMPLE_W-1:0] out_word_reg;

    logic [POS_W-1:0]  pos_eff;
    logic [BUF_W-1:0]  buf_eff;
    logic [FW_W-1:0]   fw;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              out_take;
    logic              s1_move;

    always_comb
    begin
        // A position or buffer left out of range by a config change is pulled in.
        pos_eff = ({1'b0, pos_reg} >= cfg.spf) ? POS_W'(cfg.spf - SPF_W'(1)) : pos_reg;
        buf_eff = (NB_W'(buf_reg) >= cfg.nb) ? '0 : buf_reg;
        fw      = FW_W'(cfg.cc) * FW_W'(cfg.spf);
        base    = ADDR_W'(buf_eff) * ADDR_W'(fw);
        if (cfg.layout == LAYOUT_SAMPLE_MAJOR)
        begin
            offset = ADDR_W'(pos_eff) * ADDR_W'(cfg.cc) + ADDR_W'(ch_reg);
        end
        else
        begin
            offset = ADDR_W'(ch_reg) * ADDR_W'(cfg.spf) + ADDR_W'(pos_eff);
        end
        waddr = base + offset;
        raddr = rd_base_reg + ADDR_W'(rd_idx_reg);

        out_take = !out_valid_reg || out_ready;
        s1_move  = s1_valid_reg && out_take;

        status.wr_last    = (ch_reg == CH_W'(cfg.cc - CC_W'(1)));
        status.frame_full = (SPF_W'(pos_eff) + SPF_W'(1)) >= cfg.spf;
        status.rd_last    = ({1'b0, rd_idx_reg} == (fw - FW_W'(1)));
        status.can_issue  = !s1_valid_reg || out_take;
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[waddr] <= samp_reg[ch_reg];
        end
        if (cmd.read_issue)
        begin
            rd_data_reg <= mem[raddr];
            s1_last_reg <= status.rd_last;
            s1_buf_reg  <= rd_buf_reg;
        end
        if (s1_move)
        begin
            out_word_reg <= rd_data_reg;
            out_last_reg <= s1_last_reg;
            out_buf_reg  <= s1_buf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < INPUT_CHANNELS; i++)
            begin
                samp_reg[i] <= in_samples[i*SAMPLE_W +: SAMPLE_W];
            end
        end
        if (cmd.close)
        begin
            rd_base_reg <= base;
            rd_buf_reg  <= buf_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            pos_reg       <= '0;
            buf_reg       <= '0;
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.close)
            begin
                ch_reg     <= '0;
                rd_idx_reg <= '0;
                if (status.frame_full)
                begin
                    pos_reg <= '0;
                    buf_reg <= ((NB_W'(buf_eff) + NB_W'(1)) >= cfg.nb) ? '0
                             : BUF_W'(buf_eff + BUF_W'(1));
                end
                else
                begin
                    pos_reg <= pos_eff + POS_W'(1);
                    buf_reg <= buf_eff;
                end
            end
            else if (cmd.write)
            begin
                ch_reg <= ch_reg + CH_W'(1);
            end
            if (cmd.read_issue)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmd.read_issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_buf   = out_buf_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/multichannel_sample_framer_top.sv -----
// ----------------------------------------------------------------------------
// Multichannel sample framer
// Gathers sample vectors into rotating frame buffers and streams each
// completed frame out word by word.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                   Transaction
//  s_*       in   s_tdata: sample_ch0..sample_ch3           one sample vector
//  m_*       out  m_tdata: frame_word, m_tuser, m_tlast     one frame word
//  cfg_*     in   cfg_index, cfg_wdata                      one register write
//
//  Sequence: accept a vector, then one store per active channel. A vector
//  that completes a frame then issues one read per frame word, one per cycle
//  while the read stage has room; input stays blocked until the last read is
//  issued, and the last words drain through the two-stage output pipe alone.
//  Reset: asynchronous; clears position, buffer select and valid flags.
//  Stalls: m_tready low holds the output word and backs up the read stage.
//
`include "multichannel_sample_framer_top_assert.svh"

module multichannel_sample_framer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Sample vectors in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [127:0]                   s_tdata,   // sample_ch0, ch1, ch2, ch3
    // Frame words out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // frame_word
    output logic                           m_tuser,   // buffer_index
    output logic                           m_tlast,   // last_word
    // Register writes
    input  logic                           cfg_wen,
    input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import msf_pkg::*;

    msf_cfg_t    cfg;
    msf_cmd_t    cmd;
    msf_status_t status;

    // Saturated register view feeds the datapath directly.
    msf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequence store and read-out.
    msf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, addressing and output pipe.
    msf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .in_samples (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .out_buf    (m_tuser),
        .out_last   (m_tlast)
    );

    // Never accept a vector while reads are still being issued.
    `MSF_ASSERT_IMPLY(a_no_accept_in_read, clk, rst_n, cmd.read_issue, !s_tready)
    // Never issue a read into a full pipe.
    `MSF_ASSERT_IMPLY(a_read_has_room, clk, rst_n, cmd.read_issue, status.can_issue)
    // A vector that does not complete a frame returns to accepting input.
    `MSF_ASSERT_NEXT(a_partial_back_idle, clk, rst_n,
        cmd.close && !status.frame_full, s_tready)

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Sample framer testbench
// Feeds sample vectors through the stream input and checks every frame word
// against a local frame predictor. It starts with a directed table and then
// runs random phases with register settings changed between phases. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch to back the block up.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 24;     // store pass plus output pipe, padded
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int HOLD_AFTER     = 150;    // frame words seen before the hold-off
    localparam int RANDOM_ITEMS   = 260;

    typedef enum logic {
        ROW_REG,
        ROW_VEC
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        msf_cfg_idx_t          idx;
        logic [CFG_DATA_W-1:0] val;
        logic [127:0]          vec;
        bit                    typed;     // expected word typed into the row
        logic [31:0]           exp_word;
        logic                  exp_bsel;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic        bsel;
        logic        last;
    } frame_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [127:0]          s_tdata;     // sample_ch0, ch1, ch2, ch3
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;     // frame_word
    logic                  m_tuser;     // buffer_index
    logic                  m_tlast;     // last_word
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    multichannel_sample_framer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Frame predictor state: its own copy of the store, the write position,
    // the buffer select and the raw register values.
    // ------------------------------------------------------------------------
    logic [31:0]     pm_store [STORE_DEPTH];
    bit              pm_written [STORE_DEPTH];
    int unsigned     pm_pos;
    int unsigned     pm_bsel;
    logic [CC_W-1:0]  r_cc;
    logic [SPF_W-1:0] r_spf;
    logic [NB_W-1:0]  r_nb;
    msf_layout_t      r_layout;

    frame_word_t expected_words [$];
    stim_row_t   dir_rows [$];
    int unsigned fail_count;
    int unsigned rand_sent;

    // Saturate a register value into 1..hi.
    function automatic int unsigned clamp1(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Store one vector into the predicted frame buffer; when it closes the
    // frame, queue every frame word in buffer order (unless emit is clear).
    function automatic void store_vector(input logic [127:0] v, input bit emit);
        int unsigned cc, spf, nb, fw, p, bsel, base, a;
        frame_word_t fwd;
        cc   = clamp1(r_cc, MAX_CHANNELS);
        spf  = clamp1(r_spf, MAX_SAMPLES);
        nb   = clamp1(r_nb, MAX_BUFFERS);
        fw   = cc * spf;
        p    = (pm_pos >= spf) ? spf - 1 : pm_pos;
        bsel = (pm_bsel >= nb) ? 0 : pm_bsel;
        base = bsel * fw;
        for (int c = 0; c < cc; c++) begin
            a = base + ((r_layout == LAYOUT_SAMPLE_MAJOR) ? p * cc + c : c * spf + p);
            if (a < STORE_DEPTH) begin
                pm_store[a]   = v[c*32 +: 32];
                pm_written[a] = 1'b1;
            end
        end
        p++;
        if (p < spf) begin
            pm_pos  = p;
            pm_bsel = bsel;
            return;
        end
        pm_pos  = 0;
        pm_bsel = (bsel + 1 >= nb) ? 0 : bsel + 1;
        if (emit) begin
            for (int i = 0; i < fw; i++) begin
                fwd.word = pm_store[base + i];
                fwd.bsel = bsel[0];
                fwd.last = (i + 1 == fw);
                expected_words.push_back(fwd);
            end
        end
    endfunction

    // True when every word of the frame that the given settings would read
    // already holds a known value, so a mid-frame change reads no stale entry.
    function automatic bit span_written(input int unsigned cc_raw,
                                        input int unsigned spf_raw,
                                        input int unsigned nb_raw);
        int unsigned fw, nb, bsel, base;
        fw   = clamp1(cc_raw, MAX_CHANNELS) * clamp1(spf_raw, MAX_SAMPLES);
        nb   = clamp1(nb_raw, MAX_BUFFERS);
        bsel = (pm_bsel >= nb) ? 0 : pm_bsel;
        base = bsel * fw;
        for (int i = 0; i < fw; i++)
            if (!pm_written[base + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit no_idle_window();
        return ($time >= 30000 && $time < 60000);
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_reg(input msf_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{kind: ROW_REG, idx: idx, val: val, vec: '0, typed: 1'b0,
              exp_word: '0, exp_bsel: 1'b0};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_vec(input logic [127:0] v);
        stim_row_t r;
        r = '{kind: ROW_VEC, idx: CFG_ACTIVE_CHANNELS, val: '0, vec: v, typed: 1'b0,
              exp_word: '0, exp_bsel: 1'b0};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked_vec(input logic [127:0] v, input logic [31:0] word,
                                            input logic bsel);
        stim_row_t r;
        r = '{kind: ROW_VEC, idx: CFG_ACTIVE_CHANNELS, val: '0, vec: v, typed: 1'b1,
              exp_word: word, exp_bsel: bsel};
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one vector, idling at random first; return once it is accepted.
    task automatic push_vector(input logic [127:0] v);
        while (!no_idle_window() && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Drop valid, wait until every predicted word has come out, then give the
    // block time to finish storing a vector that closed no frame.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold the write strobe high for one edge; the caller lowers it after the
    // last write of a batch.
    task automatic reg_write(input msf_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ACTIVE_CHANNELS:   r_cc     = val[CC_W-1:0];
            CFG_SAMPLES_PER_FRAME: r_spf    = val[SPF_W-1:0];
            CFG_BUFFERS_IN_USE:    r_nb     = val[NB_W-1:0];
            CFG_LAYOUT_MODE:       r_layout = msf_layout_t'(val[0]);
            default: ;
        endcase
    endtask

    task automatic send_random();
        logic [127:0] v;
        for (int c = 0; c < INPUT_CHANNELS; c++) v[c*32 +: 32] = pick_sample();
        store_vector(v, 1'b1);
        push_vector(v);
        rand_sent++;
    endtask

    // Complete the frame in progress with random vectors.
    task automatic finish_frame();
        int unsigned spf, p;
        spf = clamp1(r_spf, MAX_SAMPLES);
        p   = (pm_pos >= spf) ? spf - 1 : pm_pos;
        repeat (spf - p) send_random();
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, a quiet stretch with tready held high,
    // and one long hold-off while the sender keeps offering vectors.
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int unsigned words_seen;
        int unsigned hold_left;
        bit          hold_done;
        words_seen = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) words_seen++;
            if (!hold_done && words_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rst_n && (no_idle_window() || $urandom_range(0, 99) >= 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output check and watchdog. Each accepted frame word is compared with
    // the oldest predicted word; any cycle with a transaction or a register
    // write restarts the watchdog.
    // ------------------------------------------------------------------------
    initial begin : word_check
        frame_word_t want;
        int unsigned dead_cycles;
        dead_cycles = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                dead_cycles = 0;
                if (expected_words.size() == 0) begin
                    $error("unexpected frame word %h (buffer %0d, last %0d)",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.word) begin
                        $error("frame_word: expected %h, actual %h", want.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.bsel) begin
                        $error("buffer_index: expected %0d, actual %0d", want.bsel, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_word: expected %0d, actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end else if ((s_tvalid && s_tready) || cfg_wen || !rst_n) begin
                dead_cycles = 0;
            end else begin
                dead_cycles++;
            end
            if (dead_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed table, then random phases, then drain.
    // ------------------------------------------------------------------------
    initial begin : stim_main
        logic [127:0]          v;
        logic [CFG_DATA_W-1:0] cand [4];
        bit                    wr_en [4];
        int unsigned           new_cc, new_spf, new_nb, nvec, spf_eff;
        row_kind_t             prev_kind;
        frame_word_t           typed_word;

        fail_count = 0;
        rand_sent  = 0;
        pm_pos     = 0;
        pm_bsel    = 0;
        r_cc       = 3'd4;
        r_spf      = 5'd16;
        r_nb       = 2'd2;
        r_layout   = LAYOUT_CHANNEL_MAJOR;
        for (int i = 0; i < STORE_DEPTH; i++) pm_written[i] = 1'b0;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_ACTIVE_CHANNELS;
        cfg_wdata <= '0;

        // Reset settings: one full 4 x 16 channel-major frame into buffer 0,
        // opening and closing on the sample extremes.
        for (int s = 0; s < MAX_SAMPLES; s++) begin
            if (s == 0)
                v = {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
            else if (s == MAX_SAMPLES - 1)
                v = {32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
            else
                for (int c = 0; c < INPUT_CHANNELS; c++)
                    v[c*32 +: 32] = {4'(c), 4'(s), 24'($urandom())};
            add_vec(v);
        end
        // Zero in every sized register acts as one: each vector is a one-word
        // frame. The buffer select left at 1 is past the single buffer, so
        // buffer 0 is used.
        add_reg(CFG_ACTIVE_CHANNELS, 5'd0);
        add_reg(CFG_SAMPLES_PER_FRAME, 5'd0);
        add_reg(CFG_BUFFERS_IN_USE, 5'd0);
        add_reg(CFG_LAYOUT_MODE, 5'(LAYOUT_SAMPLE_MAJOR));
        add_checked_vec({96'($urandom()), 32'h7FFF_FFFF}, 32'h7FFF_FFFF, 1'b0);
        add_checked_vec({96'($urandom()), 32'h8000_0000}, 32'h8000_0000, 1'b0);
        // Values above the maximum saturate: 4 channels, 2 buffers.
        add_reg(CFG_ACTIVE_CHANNELS, 5'd7);
        add_reg(CFG_SAMPLES_PER_FRAME, 5'd2);
        add_reg(CFG_BUFFERS_IN_USE, 5'd3);
        add_vec({$urandom(), $urandom(), $urandom(), $urandom()});
        add_vec({$urandom(), $urandom(), $urandom(), $urandom()});
        // Mid-frame shrink: the position left past the new frame end is
        // pulled back to the last slot, so the next vector closes the frame.
        add_reg(CFG_SAMPLES_PER_FRAME, 5'd4);
        add_vec({$urandom(), $urandom(), $urandom(), $urandom()});
        add_reg(CFG_SAMPLES_PER_FRAME, 5'd1);
        add_vec({32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});

        wait (rst_n === 1'b1);
        @(posedge clk);

        prev_kind = ROW_VEC;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                if (prev_kind != ROW_REG) settle();
                reg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                if (prev_kind == ROW_REG) cfg_wen <= 1'b0;
                if (dir_rows[i].typed) begin
                    // Advance the predictor state but queue the typed word.
                    store_vector(dir_rows[i].vec, 1'b0);
                    typed_word = '{word: dir_rows[i].exp_word, bsel: dir_rows[i].exp_bsel,
                                   last: 1'b1};
                    expected_words.push_back(typed_word);
                end else begin
                    store_vector(dir_rows[i].vec, 1'b1);
                end
                push_vector(dir_rows[i].vec);
            end
            prev_kind = dir_rows[i].kind;
        end

        // Random phases: pick new register values, write them while the block
        // is idle, then send mostly whole frames with some partial ones.
        while (rand_sent < RANDOM_ITEMS) begin
            cand[0] = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                   : CFG_DATA_W'($urandom_range(1, MAX_CHANNELS));
            cand[1] = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                                   : CFG_DATA_W'($urandom_range(1, 4));
            cand[2] = CFG_DATA_W'($urandom_range(0, 3));
            cand[3] = CFG_DATA_W'($urandom_range(0, 1));
            for (int k = 0; k < 4; k++) wr_en[k] = ($urandom_range(0, 3) != 0);
            wr_en[$urandom_range(0, 3)] = 1'b1;

            new_cc  = wr_en[0] ? cand[0] : r_cc;
            new_spf = wr_en[1] ? cand[1] : r_spf;
            new_nb  = wr_en[2] ? cand[2] : r_nb;
            // Change mid-frame only where the frame to be read is fully known.
            if (pm_pos != 0 && (!span_written(new_cc, new_spf, new_nb) ||
                                $urandom_range(0, 2) == 0))
                finish_frame();

            settle();
            for (int k = 0; k < 4; k++)
                if (wr_en[k]) reg_write(msf_cfg_idx_t'(k), cand[k]);
            cfg_wen <= 1'b0;

            spf_eff = clamp1(r_spf, MAX_SAMPLES);
            if ($urandom_range(0, 4) == 0)
                nvec = $urandom_range(1, 2 * spf_eff);
            else
                nvec = spf_eff * $urandom_range(1, 3);
            repeat (nvec) send_random();
        end

        // Drain, then report.
        settle();
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
